// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in the same cycle implies consequence in the same cycle
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// condition implies consequence in the next cycle
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/kfcv_pkg.sv =====
// shared types, op codes and helpers of the constant-velocity kalman filter
package kfcv_pkg;

    localparam int DATA_W  = 32;
    localparam int UDATA_W = 31;
    localparam int ROOT_W  = 24;
    localparam int ACC_W   = 52;
    localparam int OUT_W   = 256;

    // register indexes of the configuration port
    localparam logic [2:0] REG_STEP_PERIOD = 3'd0;
    localparam logic [2:0] REG_ACCEL_VAR   = 3'd1;
    localparam logic [2:0] REG_MEAS_VAR    = 3'd2;
    localparam logic [2:0] REG_INIT_POS    = 3'd3;
    localparam logic [2:0] REG_INIT_VEL    = 3'd4;
    localparam logic [2:0] REG_INIT_PVAR   = 3'd5;
    localparam logic [2:0] REG_INIT_VVAR   = 3'd6;

    localparam logic [30:0] Q_ONE = 31'd65536;

    typedef logic [4:0] t_op;

    // datapath micro-ops, run in this order
    localparam t_op OP_G0  = 5'd0;
    localparam t_op OP_GG  = 5'd1;
    localparam t_op OP_Q00 = 5'd2;
    localparam t_op OP_GT  = 5'd3;
    localparam t_op OP_Q01 = 5'd4;
    localparam t_op OP_TT  = 5'd5;
    localparam t_op OP_Q11 = 5'd6;
    localparam t_op OP_XP  = 5'd7;
    localparam t_op OP_A00 = 5'd8;
    localparam t_op OP_A01 = 5'd9;
    localparam t_op OP_P00 = 5'd10;
    localparam t_op OP_P01 = 5'd11;
    localparam t_op OP_P10 = 5'd12;
    localparam t_op OP_P11 = 5'd13;
    localparam t_op OP_INN = 5'd14;
    localparam t_op OP_XF  = 5'd15;
    localparam t_op OP_VF  = 5'd16;
    localparam t_op OP_F00 = 5'd17;
    localparam t_op OP_F01 = 5'd18;
    localparam t_op OP_F10 = 5'd19;
    localparam t_op OP_F11 = 5'd20;

    typedef struct packed {
        logic load_in;
        logic mul_go;
        logic op_wr;
        t_op  op;
        logic div_start;
        logic div_ld;
        logic sqf_start;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic sqf_done;
    } t_dp_sts;

    function automatic logic signed [ACC_W-1:0] ext_s(input logic signed [DATA_W-1:0] v);
        return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_u(input logic [UDATA_W-1:0] v);
        return {{(ACC_W-UDATA_W){1'b0}}, v};
    endfunction

endpackage

// ===== hw/rtl/kfcv_div.sv =====
// restoring divider giving round(num * 2^16 / den), ties away from zero, saturated
module kfcv_div
    import kfcv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [31:0]       i_num,
    input  logic signed [33:0]       i_den,
    output logic                     o_done,
    output logic signed [31:0]       o_quot,
    output logic                     o_sat
);

    logic [31:0] w_nabs;
    logic [33:0] w_dabs;
    logic [47:0] w_numer;
    logic [33:0] w_trial;
    logic [33:0] w_diff;
    logic        w_ge;
    logic        w_sat_pos;
    logic        w_sat_neg;

    logic [47:0] r_q;
    logic [32:0] r_rem;
    logic [32:0] r_d;
    logic        r_neg;
    logic        r_zero;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    assign w_nabs  = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_dabs  = i_den[33] ? 34'(-i_den) : 34'(i_den);
    assign w_numer = {w_nabs, 16'd0} + {16'd0, w_dabs[32:1]};
    assign w_trial = {r_rem, r_q[47]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_ge    = (w_trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= w_numer;
            r_rem  <= '0;
            r_d    <= w_dabs[32:0];
            r_neg  <= i_num[31] ^ i_den[33];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_q   <= {r_q[46:0], w_ge};
            r_rem <= w_ge ? w_diff[32:0] : w_trial[32:0];
        end
    end

    assign w_sat_pos = |r_q[47:31];
    assign w_sat_neg = (|r_q[47:32]) || (r_q[31] && (|r_q[30:0]));

    always_comb begin
        o_sat  = 1'b0;
        o_quot = '0;
        if (!r_zero) begin
            if (r_neg) begin
                o_sat  = w_sat_neg;
                o_quot = w_sat_neg ? 32'sh8000_0000 : 32'(-r_q[31:0]);
            end else begin
                o_sat  = w_sat_pos;
                o_quot = w_sat_pos ? 32'sh7FFF_FFFF : 32'(r_q[31:0]);
            end
        end
    end

    assign o_done = r_done;

endmodule

// ===== hw/rtl/kfcv_sqrt.sv =====
// bit-serial floor square root of |v| * 2^16, one result bit per cycle
module kfcv_sqrt
    import kfcv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [31:0]       i_val,
    output logic                     o_done,
    output logic [ROOT_W-1:0]        o_root
);

    logic [31:0] w_abs;
    logic [27:0] w_cand;
    logic [27:0] w_trial;
    logic        w_ge;

    logic [47:0]       r_x;
    logic [25:0]       r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;

    assign w_abs   = i_val[31] ? 32'(-i_val) : 32'(i_val);
    assign w_cand  = {r_rem, r_x[47:46]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_cand >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= {w_abs, 16'd0};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[45:0], 2'b00};
            r_rem  <= w_ge ? 26'(w_cand - w_trial) : w_cand[25:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/kfcv_dp.sv =====
// datapath: config and filter state, shared multiply-add unit, dividers, square roots
module kfcv_dp
    import kfcv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [31:0]          i_meas,
    input  logic                 i_missing,
    output logic [OUT_W-1:0]     o_result,
    output logic                 o_saturated
);

    localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SMIN = -ACC_W'(64'sh0000_0000_8000_0000);

    // configuration and filter state
    logic [30:0]        r_t, r_va, r_r, r_pvar, r_vvar;
    logic signed [31:0] r_ipos, r_ivel;
    logic signed [31:0] r_est_p, r_est_v, r_c0, r_c1, r_c2, r_c3;

    // per-item working registers
    logic signed [31:0] r_z, r_g0, r_t1, r_q00, r_q01, r_q11, r_xp;
    logic signed [31:0] r_a00, r_a01, r_p00, r_p01, r_p10, r_p11, r_inn;
    logic signed [31:0] r_k0, r_k1, r_xf, r_vf, r_f00, r_f01, r_f10, r_f11;
    logic               r_miss, r_clip;
    logic [ROOT_W-1:0]  r_sgp;
    logic signed [65:0] r_prod;
    logic [OUT_W-1:0]   r_out;
    logic               r_out_sat;

    logic signed [32:0]      w_ma, w_mb;
    logic signed [ACC_W-1:0] w_c0, w_c1, w_m, w_res;
    logic                    w_mneg, w_g0k, w_ovf;
    logic signed [65:0]      w_rnd, w_grnd;
    logic signed [31:0]      w_sat;
    logic [30:0]             w_ipvar, w_ivvar;
    logic signed [31:0]      w_ipos, w_ivel;
    logic signed [33:0]      w_den;
    logic signed [31:0]      w_k0, w_k1, w_sqa_in, w_sqb_in;
    logic                    w_k0_sat, w_k1_sat, w_k0_done, w_k1_done;
    logic                    w_sqa_done, w_sqb_done;
    logic [ROOT_W-1:0]       w_sqa_root, w_sqb_root;

    function automatic logic signed [32:0] sx(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    // ---- configuration and state reload ----
    assign w_ipos  = (i_cfg_index == REG_INIT_POS)  ? i_cfg_data       : r_ipos;
    assign w_ivel  = (i_cfg_index == REG_INIT_VEL)  ? i_cfg_data       : r_ivel;
    assign w_ipvar = (i_cfg_index == REG_INIT_PVAR) ? i_cfg_data[30:0] : r_pvar;
    assign w_ivvar = (i_cfg_index == REG_INIT_VVAR) ? i_cfg_data[30:0] : r_vvar;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t     <= Q_ONE;
            r_va    <= Q_ONE;
            r_r     <= Q_ONE;
            r_ipos  <= '0;
            r_ivel  <= '0;
            r_pvar  <= Q_ONE;
            r_vvar  <= Q_ONE;
            r_est_p <= '0;
            r_est_v <= '0;
            r_c0    <= 32'(Q_ONE);
            r_c1    <= '0;
            r_c2    <= '0;
            r_c3    <= 32'(Q_ONE);
        end else if (i_cfg_we && i_cfg_index <= REG_INIT_VVAR) begin
            unique case (i_cfg_index)
                REG_STEP_PERIOD: r_t  <= i_cfg_data[30:0];
                REG_ACCEL_VAR:   r_va <= i_cfg_data[30:0];
                REG_MEAS_VAR:    r_r  <= i_cfg_data[30:0];
                default: ;
            endcase
            r_ipos  <= w_ipos;
            r_ivel  <= w_ivel;
            r_pvar  <= w_ipvar;
            r_vvar  <= w_ivvar;
            r_est_p <= w_ipos;
            r_est_v <= w_ivel;
            r_c0    <= {1'b0, w_ipvar};
            r_c1    <= '0;
            r_c2    <= '0;
            r_c3    <= {1'b0, w_ivvar};
        end else if (i_cmd.commit) begin
            r_est_p <= r_xf;
            r_est_v <= r_vf;
            r_c0    <= r_f00;
            r_c1    <= r_f01;
            r_c2    <= r_f10;
            r_c3    <= r_f11;
        end
    end

    // ---- operand selection of the shared multiply-add unit ----
    always_comb begin
        w_ma   = '0;
        w_mb   = '0;
        w_c0   = '0;
        w_c1   = '0;
        w_mneg = 1'b0;
        w_g0k  = 1'b0;
        case (i_cmd.op)
            OP_G0:  begin w_ma = {2'b00, r_t}; w_mb = {2'b00, r_t}; w_g0k = 1'b1; end
            OP_GG:  begin w_ma = sx(r_g0); w_mb = sx(r_g0); end
            OP_Q00: begin w_ma = {2'b00, r_va}; w_mb = sx(r_t1); end
            OP_GT:  begin w_ma = sx(r_g0); w_mb = {2'b00, r_t}; end
            OP_Q01: begin w_ma = {2'b00, r_va}; w_mb = sx(r_t1); end
            OP_TT:  begin w_ma = {2'b00, r_t}; w_mb = {2'b00, r_t}; end
            OP_Q11: begin w_ma = {2'b00, r_va}; w_mb = sx(r_t1); end
            OP_XP:  begin w_ma = {2'b00, r_t}; w_mb = sx(r_est_v); w_c0 = ext_s(r_est_p); end
            OP_A00: begin w_ma = {2'b00, r_t}; w_mb = sx(r_c2); w_c0 = ext_s(r_c0); end
            OP_A01: begin w_ma = {2'b00, r_t}; w_mb = sx(r_c3); w_c0 = ext_s(r_c1); end
            OP_P00: begin
                w_ma = {2'b00, r_t}; w_mb = sx(r_a01);
                w_c0 = ext_s(r_a00); w_c1 = ext_s(r_q00);
            end
            OP_P01: begin w_c0 = ext_s(r_a01); w_c1 = ext_s(r_q01); end
            OP_P10: begin
                w_ma = {2'b00, r_t}; w_mb = sx(r_c3);
                w_c0 = ext_s(r_c2); w_c1 = ext_s(r_q01);
            end
            OP_P11: begin w_c0 = ext_s(r_c3); w_c1 = ext_s(r_q11); end
            OP_INN: begin w_c0 = ext_s(r_z); w_c1 = -ext_s(r_xp); end
            OP_XF:  begin w_ma = sx(r_k0); w_mb = sx(r_inn); w_c0 = ext_s(r_xp); end
            OP_VF:  begin w_ma = sx(r_k1); w_mb = sx(r_inn); w_c0 = ext_s(r_est_v); end
            OP_F00: begin w_ma = sx(r_k0); w_mb = sx(r_p00); w_c0 = ext_s(r_p00); w_mneg = 1'b1; end
            OP_F01: begin w_ma = sx(r_k0); w_mb = sx(r_p01); w_c0 = ext_s(r_p01); w_mneg = 1'b1; end
            OP_F10: begin w_ma = sx(r_k1); w_mb = sx(r_p00); w_c0 = ext_s(r_p10); w_mneg = 1'b1; end
            OP_F11: begin w_ma = sx(r_k1); w_mb = sx(r_p01); w_c0 = ext_s(r_p11); w_mneg = 1'b1; end
            default: ;
        endcase
    end

    // product rounded to nearest, ties up; half t^2 rounded the same way
    assign w_rnd  = r_prod + 66'sd32768;
    assign w_grnd = r_prod + 66'sd65536;
    assign w_m    = w_g0k ? ACC_W'($signed(w_grnd[65:17])) : ACC_W'($signed(w_rnd[65:16]));
    assign w_res  = w_c0 + (w_mneg ? -w_m : w_m) + w_c1;
    assign w_ovf  = (w_res > SMAX) || (w_res < SMIN);
    assign w_sat  = (w_res > SMAX) ? 32'sh7FFF_FFFF :
                    (w_res < SMIN) ? 32'sh8000_0000 : w_res[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_prod <= w_ma * w_mb;
        end
        if (i_cmd.load_in) begin
            r_z    <= i_meas;
            r_miss <= i_missing;
            r_clip <= 1'b0;
        end
        if (i_cmd.op_wr) begin
            r_clip <= r_clip | w_ovf;
            case (i_cmd.op)
                OP_G0:  r_g0  <= w_sat;
                OP_GG:  r_t1  <= w_sat;
                OP_Q00: r_q00 <= w_sat;
                OP_GT:  r_t1  <= w_sat;
                OP_Q01: r_q01 <= w_sat;
                OP_TT:  r_t1  <= w_sat;
                OP_Q11: r_q11 <= w_sat;
                OP_XP:  r_xp  <= w_sat;
                OP_A00: r_a00 <= w_sat;
                OP_A01: r_a01 <= w_sat;
                OP_P00: r_p00 <= w_sat;
                OP_P01: r_p01 <= w_sat;
                OP_P10: r_p10 <= w_sat;
                OP_P11: r_p11 <= w_sat;
                OP_INN: r_inn <= w_sat;
                OP_XF:  r_xf  <= w_sat;
                OP_VF:  r_vf  <= w_sat;
                OP_F00: r_f00 <= w_sat;
                OP_F01: r_f01 <= w_sat;
                OP_F10: r_f10 <= w_sat;
                OP_F11: r_f11 <= w_sat;
                default: ;
            endcase
        end
        if (i_cmd.div_ld) begin
            r_k0   <= w_k0;
            r_k1   <= w_k1;
            r_sgp  <= w_sqa_root;
            r_clip <= r_clip | w_k0_sat | w_k1_sat;
            // a gap keeps the prediction
            if (r_miss) begin
                r_xf  <= r_xp;
                r_vf  <= r_est_v;
                r_f00 <= r_p00;
                r_f01 <= r_p01;
                r_f10 <= r_p10;
                r_f11 <= r_p11;
            end
        end
        if (i_cmd.commit) begin
            r_out <= {3'b000,
                      {(UDATA_W-ROOT_W){1'b0}}, w_sqb_root,
                      {(UDATA_W-ROOT_W){1'b0}}, w_sqa_root,
                      {(UDATA_W-ROOT_W){1'b0}}, r_sgp,
                      r_k1, r_k0, r_vf, r_xf, r_xp};
            r_out_sat <= r_clip;
        end
    end

    // ---- gain division and square roots ----
    assign w_den = {{2{r_p00[31]}}, r_p00} + {3'b000, r_r};

    kfcv_div u_div_k0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_p00),
        .i_den   (w_den),
        .o_done  (w_k0_done),
        .o_quot  (w_k0),
        .o_sat   (w_k0_sat)
    );

    kfcv_div u_div_k1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_p10),
        .i_den   (w_den),
        .o_done  (w_k1_done),
        .o_quot  (w_k1),
        .o_sat   (w_k1_sat)
    );

    // unit a takes the predicted variance first, then the filtered one
    assign w_sqa_in = i_cmd.sqf_start ? (r_miss ? r_p00 : r_f00) : r_p00;
    assign w_sqb_in = r_miss ? r_p11 : r_f11;

    kfcv_sqrt u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start | i_cmd.sqf_start),
        .i_val   (w_sqa_in),
        .o_done  (w_sqa_done),
        .o_root  (w_sqa_root)
    );

    kfcv_sqrt u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqf_start),
        .i_val   (w_sqb_in),
        .o_done  (w_sqb_done),
        .o_root  (w_sqb_root)
    );

    assign o_sts.div_done = w_k0_done & w_k1_done & w_sqa_done;
    assign o_sts.sqf_done = w_sqa_done & w_sqb_done;
    assign o_result       = r_out;
    assign o_saturated    = r_out_sat;

endmodule

// ===== hw/rtl/kfcv_ctrl.sv =====
// controller: sequences the micro-ops, the division and the square roots of one item
module kfcv_ctrl
    import kfcv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_in_missing,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SQF  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;
    localparam logic [2:0] S_SQS  = 3'd6;

    logic [2:0] r_state, n_state;
    t_op        r_op, n_op;
    logic       r_miss, n_miss;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_miss        = r_miss;
        o_cmd         = '0;
        o_cmd.op      = r_op;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_miss        = i_in_missing;
                    n_op          = OP_G0;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_state      = S_WR;
            end
            S_WR: begin
                o_cmd.op_wr = 1'b1;
                if ((r_op == OP_P11 && r_miss) || r_op == OP_INN) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (r_op == OP_F11) begin
                    n_state = S_SQS;
                end else begin
                    n_op    = r_op + 5'd1;
                    n_state = S_MUL;
                end
            end
            // roots start once the last filtered variance is stored
            S_SQS: begin
                o_cmd.sqf_start = 1'b1;
                n_state         = S_SQF;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_ld = 1'b1;
                    if (r_miss) begin
                        o_cmd.sqf_start = 1'b1;
                        n_state         = S_SQF;
                    end else begin
                        n_op    = OP_XF;
                        n_state = S_MUL;
                    end
                end
            end
            S_SQF: begin
                if (i_sts.sqf_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_G0;
            r_miss      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_miss      <= n_miss;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/kalman_filter_const_velocity.sv =====
// one item is in work at a time; its time from input transfer to result is set by
//   the 48-step gain dividers, the shared multiply-add unit (a multiply and a write state
//   per micro-op, 21 micro-ops, 14 on a gap) and a root pass
// a new input is taken while the previous result still waits in the output register
// reset (synchronous, active low) loads the register defaults and reloads the filter state;
//   every write to one of the seven config registers reloads the state too, no clearing pass is needed
module kalman_filter_const_velocity
    import kfcv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    // input stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [31:0]       i_s_axis_tdata,   // [31:0] measurement
    input  logic              i_s_axis_tuser,   // [0] meas_missing
    // result stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_W-1:0]  o_m_axis_tdata,   // [31:0] pred_position, [63:32] filt_position,
                                                // [95:64] filt_velocity, [127:96] gain_position,
                                                // [159:128] gain_velocity,
                                                // [190:160] sigma_pred_position,
                                                // [221:191] sigma_position,
                                                // [252:222] sigma_velocity, [255:253] zero
    output logic              o_m_axis_tuser    // [0] saturated
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_xfer;

    // config is always taken; the user must write only while the filter is idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_s_axis_tvalid & o_s_axis_tready;

    // sequencer: walks the predict, gain and update steps
    kfcv_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_in_missing (i_s_axis_tuser),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_cmd        (w_cmd),
        .i_sts        (w_sts)
    );

    // arithmetic, filter state, config registers and the result register
    kfcv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_meas      (w_in_xfer ? i_s_axis_tdata : 32'd0),
        .i_missing   (i_s_axis_tuser),
        .o_result    (o_m_axis_tdata),
        .o_saturated (o_m_axis_tuser)
    );

endmodule

// ===== hw/rtl/kfcv_checker.sv =====
// port-level checker of the kalman filter and its bind
`include "assert_macros.svh"

module kfcv_checker
    import kfcv_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    // a stalled result stays put
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // one item in work at a time
    `AST_NEXT(a_one_item, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // square roots never exceed 24 bits and the padding is zero
    `AST_IMPL(a_sigma_range, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[190:184] == 7'd0 && o_m_axis_tdata[221:215] == 7'd0 && o_m_axis_tdata[255:246] == 10'd0)

endmodule

bind kalman_filter_const_velocity kfcv_checker u_kfcv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/kalman_filter_const_velocity_chk.sv =====
// result checker for the constant-velocity kalman filter: predicts and compares
`timescale 1ns / 1ps
module kalman_filter_const_velocity_chk
    import kfcv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [31:0]      i_s_tdata,
    input  logic             i_s_tuser,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,
    input  logic             i_m_tuser,
    output int               o_errors,
    output int               o_pending,
    output int               o_seen,
    output int               o_clipped
);
    typedef struct packed {
        logic             sat;
        logic [OUT_W-1:0] data;
    } t_estimate;

    t_estimate expected_q[$];
    longint    period, acc_var, meas_var, init_pos, init_vel, init_pvar, init_vvar;
    longint    pos_est, vel_est;
    longint    cov [4];
    bit        clip;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin clip = 1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin clip = 1; return -64'sd2147483648; end
        return v;
    endfunction

    // q16 product, round to nearest, ties up
    function automatic longint qmul(longint a, longint b);
        longint r;
        r = a * b + 32768;
        return r >>> 16;
    endfunction

    // q16 quotient, ties away from zero
    function automatic longint qdiv(longint num, longint den);
        longint n, d, q;
        if (den == 0) return 0;
        n = (num < 0 ? -num : num) <<< 16;
        d = den < 0 ? -den : den;
        q = (n + d / 2) / d;
        return clamp32(((num < 0) != (den < 0)) ? -q : q);
    endfunction

    function automatic logic [30:0] qroot(longint v);
        longint unsigned x, res, b;
        x = (v < 0 ? -v : v) << 16;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin x -= res + b; res = (res >> 1) + b; end
            else res >>= 1;
            b >>= 2;
        end
        return res[30:0];
    endfunction

    task automatic reload_state();
        pos_est = init_pos; vel_est = init_vel;
        cov[0] = init_pvar; cov[1] = 0; cov[2] = 0; cov[3] = init_vvar;
    endtask

    task automatic filter_step(logic [31:0] z_raw, logic missing);
        longint t, g0, q00, q01, q11, xp, vp, a00, a01, a10, a11;
        longint p00, p01, p10, p11, k0, k1, inn, xf, vf, f00, f01, f10, f11;
        t_estimate e;
        clip = 0;
        t = period;
        g0 = clamp32((t * t + 65536) >>> 17);
        q00 = clamp32(qmul(acc_var, clamp32(qmul(g0, g0))));
        q01 = clamp32(qmul(acc_var, clamp32(qmul(g0, t))));
        q11 = clamp32(qmul(acc_var, clamp32(qmul(t, t))));
        xp = clamp32(pos_est + qmul(t, vel_est));
        vp = vel_est;
        a00 = clamp32(cov[0] + qmul(t, cov[2]));
        a01 = clamp32(cov[1] + qmul(t, cov[3]));
        a10 = cov[2]; a11 = cov[3];
        p00 = clamp32(a00 + qmul(t, a01) + q00);
        p01 = clamp32(a01 + q01);
        p10 = clamp32(a10 + qmul(t, a11) + q01);
        p11 = clamp32(a11 + q11);
        k0 = qdiv(p00, p00 + meas_var);
        k1 = qdiv(p10, p00 + meas_var);
        if (missing) begin
            xf = xp; vf = vp; f00 = p00; f01 = p01; f10 = p10; f11 = p11;
        end else begin
            inn = clamp32(longint'($signed(z_raw)) - xp);
            xf = clamp32(xp + qmul(k0, inn));
            vf = clamp32(vp + qmul(k1, inn));
            f00 = clamp32(p00 - qmul(k0, p00));
            f01 = clamp32(p01 - qmul(k0, p01));
            f10 = clamp32(p10 - qmul(k1, p00));
            f11 = clamp32(p11 - qmul(k1, p01));
        end
        pos_est = xf; vel_est = vf;
        cov[0] = f00; cov[1] = f01; cov[2] = f10; cov[3] = f11;
        e.data = '0;
        e.data[31:0] = xp[31:0];
        e.data[63:32] = xf[31:0];
        e.data[95:64] = vf[31:0];
        e.data[127:96] = k0[31:0];
        e.data[159:128] = k1[31:0];
        e.data[190:160] = qroot(p00);
        e.data[221:191] = qroot(f00);
        e.data[252:222] = qroot(f11);
        e.sat = clip;
        expected_q.insert(expected_q.size(), e);
    endtask

    task automatic check_field(string nm, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t %s mismatch: expected %h actual %h", $realtime, nm, exp_v, act_v);
            o_errors++;
        end
    endtask

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_estimate e;
        if (!i_rst_n) begin
            period = 65536; acc_var = 65536; meas_var = 65536;
            init_pos = 0; init_vel = 0; init_pvar = 65536; init_vvar = 65536;
            reload_state();
            expected_q.delete();
            o_errors = 0;
            o_seen <= 0; o_clipped <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index <= REG_INIT_VVAR) begin
                case (i_cfg_index)
                    REG_STEP_PERIOD: period    = i_cfg_data[30:0];
                    REG_ACCEL_VAR:   acc_var   = i_cfg_data[30:0];
                    REG_MEAS_VAR:    meas_var  = i_cfg_data[30:0];
                    REG_INIT_POS:    init_pos  = longint'($signed(i_cfg_data));
                    REG_INIT_VEL:    init_vel  = longint'($signed(i_cfg_data));
                    REG_INIT_PVAR:   init_pvar = i_cfg_data[30:0];
                    REG_INIT_VVAR:   init_vvar = i_cfg_data[30:0];
                    default: ;
                endcase
                reload_state();
            end
            if (i_m_tvalid && i_m_tready) begin
                o_seen <= o_seen + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h", $realtime,
                             i_m_tdata);
                    o_errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (e.sat) o_clipped <= o_clipped + 1;
                    check_field("pred_position", e.data[31:0], i_m_tdata[31:0]);
                    check_field("filt_position", e.data[63:32], i_m_tdata[63:32]);
                    check_field("filt_velocity", e.data[95:64], i_m_tdata[95:64]);
                    check_field("gain_position", e.data[127:96], i_m_tdata[127:96]);
                    check_field("gain_velocity", e.data[159:128], i_m_tdata[159:128]);
                    check_field("sigma_pred_position", e.data[190:160], i_m_tdata[190:160]);
                    check_field("sigma_position", e.data[221:191], i_m_tdata[221:191]);
                    check_field("sigma_velocity", e.data[252:222], i_m_tdata[252:222]);
                    check_field("pad", '0, i_m_tdata[255:253]);
                    check_field("saturated", e.sat, i_m_tuser);
                end
            end
            if (i_s_tvalid && i_s_tready) filter_step(i_s_tdata, i_s_tuser);
        end
    end
endmodule

// ===== tb/kalman_filter_const_velocity_tb.sv =====
// stimulus and verdict for the constant-velocity kalman filter
`timescale 1ns / 1ps
module kalman_filter_const_velocity_tb;
    import kfcv_pkg::*;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_cfg_valid = 0;
    logic             o_cfg_ready;
    logic [2:0]       i_cfg_index = REG_STEP_PERIOD;
    logic [31:0]      i_cfg_data = '0;
    logic             i_s_axis_tvalid = 0;
    logic             o_s_axis_tready;
    logic [31:0]      i_s_axis_tdata = '0;
    logic             i_s_axis_tuser = 0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 0;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             o_m_axis_tuser;

    int  n_errors, n_pending, n_seen, n_clipped;
    int  n_sent = 0;
    int  n_settings = 0;
    bit  hold_off = 0;       // long receiver stall, set by the stimulus
    bit  rx_free = 0;        // no receiver stalls at all

    always #5 i_clk = ~i_clk;

    kalman_filter_const_velocity DUT (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .i_s_axis_tvalid, .o_s_axis_tready, .i_s_axis_tdata, .i_s_axis_tuser,
        .o_m_axis_tvalid, .i_m_axis_tready, .o_m_axis_tdata, .o_m_axis_tuser
    );

    kalman_filter_const_velocity_chk u_chk (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_s_tvalid(i_s_axis_tvalid), .i_s_tready(o_s_axis_tready),
        .i_s_tdata(i_s_axis_tdata), .i_s_tuser(i_s_axis_tuser),
        .i_m_tvalid(o_m_axis_tvalid), .i_m_tready(i_m_axis_tready),
        .i_m_tdata(o_m_axis_tdata), .i_m_tuser(o_m_axis_tuser),
        .o_errors(n_errors), .o_pending(n_pending), .o_seen(n_seen),
        .o_clipped(n_clipped)
    );

    // receiver: its own stall pattern, stretches of free flow, long hold-off on demand
    always @(posedge i_clk) begin
        if (!i_rst_n) i_m_axis_tready <= 0;
        else if (hold_off) i_m_axis_tready <= 0;
        else if (rx_free) i_m_axis_tready <= 1;
        else i_m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // one register write through the config channel; valid is dropped before the task returns
    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // one measurement transfer, held until accepted
    task automatic send_meas(logic [31:0] z, logic missing);
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata  <= z;
        i_s_axis_tuser  <= missing;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_sent++;
    endtask

    // random gap after a burst; valid drops only when there is a gap
    task automatic maybe_gap();
        int g;
        if ($urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 0;
            g = $urandom_range(1, 150);
            repeat (g) @(posedge i_clk);
        end
    endtask

    // wait for all results, then let the block settle
    task automatic drain();
        i_s_axis_tvalid <= 0;
        while (n_pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_meas();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return $urandom();
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_u31(int kind);
        case (kind)
            0:       return 32'd0;
            1:       return 32'h7fff_ffff;
            2:       return $urandom() >> 1;
            default: return $urandom_range(256, 32'h0004_0000);
        endcase
    endfunction

    // a setting of all seven registers, mostly moderate values
    task automatic random_setting(bit extreme);
        cfg_write(REG_STEP_PERIOD, extreme ? rand_u31($urandom_range(0, 3))
                                           : $urandom_range(4096, 131072));
        cfg_write(REG_ACCEL_VAR, extreme ? rand_u31($urandom_range(0, 3))
                                         : $urandom_range(0, 4 * 65536));
        cfg_write(REG_MEAS_VAR, extreme ? rand_u31($urandom_range(0, 3))
                                        : $urandom_range(0, 8 * 65536));
        cfg_write(REG_INIT_POS, extreme ? $urandom() : rand_meas());
        cfg_write(REG_INIT_VEL, extreme ? $urandom() : $urandom_range(0, 131072) - 65536);
        cfg_write(REG_INIT_PVAR, extreme ? rand_u31($urandom_range(0, 3))
                                         : $urandom_range(0, 16 * 65536));
        cfg_write(REG_INIT_VVAR, extreme ? rand_u31($urandom_range(0, 3))
                                         : $urandom_range(0, 16 * 65536));
        n_settings++;
    endtask

    initial begin
        #20_000_000;
        $display("timeout after %0d items, %0d results", n_sent, n_seen);
        $display("kalman_filter_const_velocity_tb: done, errors");
        $finish;
    end

    initial begin
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset defaults, field extremes, gaps in the measurement
        send_meas(32'h0000_0000, 0);
        send_meas(32'h7fff_ffff, 0);
        send_meas(32'h8000_0000, 0);
        send_meas(32'hffff_ffff, 1);
        send_meas(32'h0001_0000, 1);
        send_meas(32'h0001_0000, 0);
        drain();

        // zero step period and zero noise: zero divisor on the gain
        cfg_write(REG_STEP_PERIOD, 32'd0);
        cfg_write(REG_ACCEL_VAR, 32'd0);
        cfg_write(REG_MEAS_VAR, 32'd0);
        cfg_write(REG_INIT_PVAR, 32'd0);
        cfg_write(REG_INIT_VVAR, 32'd0);
        send_meas(32'h0003_0000, 0);
        send_meas(32'h0003_0000, 1);
        drain();

        // largest register values, most negative initial velocity: drives saturation
        cfg_write(REG_STEP_PERIOD, 32'h7fff_ffff);
        cfg_write(REG_ACCEL_VAR, 32'h7fff_ffff);
        cfg_write(REG_MEAS_VAR, 32'h7fff_ffff);
        cfg_write(REG_INIT_POS, 32'h7fff_ffff);
        cfg_write(REG_INIT_VEL, 32'h8000_0000);
        cfg_write(REG_INIT_PVAR, 32'h7fff_ffff);
        cfg_write(REG_INIT_VVAR, 32'h7fff_ffff);
        send_meas(32'h8000_0000, 0);
        send_meas(32'h7fff_ffff, 0);
        send_meas(32'h0000_0000, 1);
        drain();

        // pressure: receiver holds off while the sender keeps offering
        random_setting(0);
        hold_off = 1;
        fork
            begin
                for (k = 0; k < 6; k++) send_meas(rand_meas(), 0);
                i_s_axis_tvalid <= 0;
            end
            begin
                repeat (1500) @(posedge i_clk);
                hold_off = 0;
            end
        join
        drain();

        // random phases: mostly plausible tracks, some extreme settings
        while (n_sent < 2000) begin
            random_setting(n_settings % 5 == 0);
            rx_free = ($urandom_range(0, 3) == 0);
            for (k = 0; k < 60; k++) begin
                send_meas(rand_meas(), $urandom_range(0, 4) == 0);
                maybe_gap();
            end
            drain();
        end

        $display("covered %0d items over %0d register settings, %0d results, %0d saturated",
                 n_sent, n_settings, n_seen, n_clipped);
        if (n_errors == 0)
            $display("kalman_filter_const_velocity_tb: done, clean");
        else
            $display("kalman_filter_const_velocity_tb: done, errors");
        $finish;
    end
endmodule
